[sv/srba_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srba_pkg
// Types, constants and helpers for the radial power-spectrum bin accumulator.
// ----------------------------------------------------------------------------
package srba_pkg;

    localparam int MAX_BINS  = 32;
    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int CT_W      = $clog2(MAX_BINS) + 1;
    localparam int DV_W      = 80;
    localparam int DV_CNT_W  = $clog2(DV_W);

    localparam logic [29:0] COUNT_MAX = 30'h3FFF_FFFF;

    // register reset values
    localparam logic [10:0] RST_GRID   = 11'd128;
    localparam logic [31:0] RST_KST    = 32'd351382;
    localparam logic [31:0] RST_KSL    = 32'd351382;
    localparam logic [31:0] RST_FBC    = 32'd351382;
    localparam logic [15:0] RST_GROW   = 16'd22118;
    localparam logic [31:0] RST_KLIM   = 32'd44976896;
    localparam logic [47:0] RST_PSCALE = 48'd34610000000;

    typedef enum logic [2:0] {
        CFG_GRID   = 3'd0,
        CFG_KST    = 3'd1,
        CFG_KSL    = 3'd2,
        CFG_FBC    = 3'd3,
        CFG_GROW   = 3'd4,
        CFG_KLIM   = 3'd5,
        CFG_PSCALE = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [9:0]         index_x;
        logic [9:0]         index_y;
        logic [9:0]         index_z;
        logic signed [31:0] coef_real;
        logic signed [31:0] coef_imag;
        logic               last_coef;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  bin_number;
        logic [29:0] mode_count;
        logic [31:0] mean_wavenumber;
        logic [63:0] mean_power;
        logic [63:0] power_error;
        logic        final_bin;
    } t_out_item;

    typedef struct packed {
        logic [29:0] count;
        logic [63:0] ksum;
        logic [63:0] psum;
    } t_bin_entry;

    typedef enum logic [4:0] {
        ST_IDLE, ST_KX, ST_KY, ST_KZ, ST_SQX, ST_SQY, ST_SQZ, ST_SQRT,
        ST_BIN, ST_ABSR, ST_ABSI, ST_LMUL, ST_RD, ST_WR, ST_LAST,
        ST_RO_RD, ST_RO_CHK, ST_DIVK, ST_DIVP, ST_RSQRT, ST_DIVE, ST_PUT
    } t_state;

    // transverse index folded to its wavenumber magnitude
    function automatic logic [10:0] wrap_mag(logic [9:0] n, logic [10:0] dim);
        logic [10:0] nn;
        nn = {1'b0, n};
        if (nn > (dim >> 1)) begin
            return (nn <= dim) ? (dim - nn) : (nn - dim);
        end
        return nn;
    endfunction

endpackage
`default_nettype wire

[sv/spectrum_radial_bin_accumulator_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spectrum_radial_bin_accumulator_unit
// Geometric-bin accumulator of a spherically averaged power spectrum.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+-------------------------------
//  in      | in  | i_in_valid / o_in_ready | i_in_item  (t_in_item)
//  out     | out | o_out_valid/ i_out_ready| o_out_item (t_out_item)
//  cfg     | in  | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
//  One item at a time. A coefficient with nonzero x and y indices goes through
//  wavenumber products and squares on the shared 32x32 multiplier, a 32-step
//  bit-serial square root, one edge per cycle in the bin search and, if a bin
//  is hit, 19 limb products for k^3*|c|^2*scale, then a read-modify-write of
//  the bin memory (registered read). Readout passes over empty bins one by one
//  and runs three 80-step divisions and a root for each reported bin.
//  Reset is synchronous; valid bits make all bins read as zero, no sweep.
//  A waiting result sits in the output register; the next item is accepted.
// ----------------------------------------------------------------------------
module spectrum_radial_bin_accumulator_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output      logic                 o_in_ready,
    input  wire srba_pkg::t_in_item   i_in_item,
    output      logic                 o_out_valid,
    input  wire logic                 i_out_ready,
    output      srba_pkg::t_out_item  o_out_item,
    input  wire logic                 i_cfg_valid,
    output      logic                 o_cfg_ready,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [47:0]          i_cfg_data
);

    // configuration
    logic [10:0] r_grid;
    logic [31:0] r_kst, r_ksl, r_fbc, r_klim;
    logic [15:0] r_grow;
    logic [47:0] r_pscale;

    srba_pkg::t_state r_state, n_state;
    srba_pkg::t_in_item r_item;

    // wavenumber path
    logic [31:0] r_kx, r_ky, r_kz, r_k;
    logic        r_kovf, r_sovf;
    logic [63:0] r_ssum;
    logic [31:0] r_lo;
    logic [33:0] r_hi;
    logic [srba_pkg::CT_W-1:0]  r_ct;
    logic [srba_pkg::BIN_W-1:0] r_bin;

    // limb multiplier
    logic [63:0] r_m;
    logic [31:0] r_opa [5];
    logic [31:0] r_acc [7];
    logic [31:0] acc_upd [7];
    logic [2:0]  r_li;
    logic        r_lj;
    logic [1:0]  r_stage;
    logic [31:0] r_carry;

    // root and divider
    logic [63:0] r_sq_v, r_sq_res, r_sq_bit;
    logic [srba_pkg::DV_W-1:0] r_dv_num;
    logic [31:0] r_dv_rem, r_dv_div;
    logic [srba_pkg::DV_CNT_W-1:0] r_dv_cnt;

    // readout
    logic [srba_pkg::BIN_W-1:0] r_rob;
    logic [29:0] r_cnt;
    logic [63:0] r_ps, r_mp;
    logic [31:0] r_mk;

    // bin memory
    srba_pkg::t_bin_entry r_mem [srba_pkg::MAX_BINS];
    srba_pkg::t_bin_entry r_rdata, cur, upd;
    logic [srba_pkg::MAX_BINS-1:0] r_valid;

    logic        r_ov;
    srba_pkg::t_out_item r_out;

    // control decode
    logic        in_acc, out_load, mem_re, mem_we, clr_valid;
    logic [srba_pkg::BIN_W-1:0] mem_raddr;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    // datapath helpers
    logic [64:0] ss_add;
    logic        bin_live, bin_hit;
    logic [31:0] ar, ai, re_u, im_u;
    logic [2:0]  na_m1, idx0, idx1;
    logic        nb_m1, l_jlast, l_ilast, l_done;
    logic [31:0] l_b;
    logic [63:0] l_t;
    logic [63:0] sq_trial, sq_v_n, sq_res_n;
    logic        sq_ge, sq_done;
    logic [32:0] dv_sh, dv_sub;
    logic        dv_ge, dv_done;
    logic [63:0] pterm;
    logic [64:0] ks_add, ps_add;
    logic        ro_fin;
    logic [srba_pkg::MAX_BINS-1:0] above;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;
    assign in_acc      = i_in_valid && o_in_ready;
    assign mul_p       = {32'b0, mul_a} * {32'b0, mul_b};

    assign re_u = r_item.coef_real;
    assign im_u = r_item.coef_imag;
    assign ar   = re_u[31] ? (~re_u + 32'd1) : re_u;
    assign ai   = im_u[31] ? (~im_u + 32'd1) : im_u;

    assign ss_add   = {1'b0, r_ssum} + {1'b0, mul_p};
    assign bin_live = (r_hi < {2'b0, r_klim}) && (r_ct < srba_pkg::CT_W'(srba_pkg::MAX_BINS));
    assign bin_hit  = (r_k >= r_lo) && ({2'b0, r_k} < r_hi);

    // limb engine: one 32x32 product per cycle, schoolbook order
    always_comb begin
        case (r_stage)
            2'd0:    begin na_m1 = 3'd0; nb_m1 = 1'b0; l_b = r_k; end
            2'd1:    begin na_m1 = 3'd1; nb_m1 = 1'b0; l_b = r_k; end
            2'd2:    begin na_m1 = 3'd2; nb_m1 = 1'b1;
                           l_b = r_lj ? r_m[63:32] : r_m[31:0]; end
            default: begin na_m1 = 3'd4; nb_m1 = 1'b1;
                           l_b = r_lj ? {16'b0, r_pscale[47:32]} : r_pscale[31:0]; end
        endcase
    end

    assign l_jlast = (r_lj == nb_m1);
    assign l_ilast = (r_li == na_m1);
    assign l_done  = l_jlast && l_ilast;
    assign idx0    = r_li + {2'b0, r_lj};
    assign idx1    = idx0 + 3'd1;
    assign l_t     = mul_p + {32'b0, r_acc[idx0]} + {32'b0, r_carry};

    always_comb begin
        acc_upd = r_acc;
        acc_upd[idx0] = l_t[31:0];
        if (l_jlast) begin
            acc_upd[idx1] = l_t[63:32];
        end
    end

    assign pterm = (|r_acc[6][31:16]) ? '1
                 : {r_acc[6][15:0], r_acc[5], r_acc[4][31:16]};

    // bit-serial root
    assign sq_trial = r_sq_res + r_sq_bit;
    assign sq_ge    = (r_sq_v >= sq_trial);
    assign sq_v_n   = sq_ge ? (r_sq_v - sq_trial) : r_sq_v;
    assign sq_res_n = sq_ge ? ((r_sq_res >> 1) + r_sq_bit) : (r_sq_res >> 1);
    assign sq_done  = r_sq_bit[0];

    // restoring divider, quotient shifts into the dividend register
    assign dv_sh   = {r_dv_rem, r_dv_num[srba_pkg::DV_W-1]};
    assign dv_ge   = (dv_sh >= {1'b0, r_dv_div});
    assign dv_sub  = dv_sh - {1'b0, r_dv_div};
    assign dv_done = (r_dv_cnt == '0);

    // bin update
    assign cur    = r_valid[r_bin] ? r_rdata : '0;
    assign ks_add = {1'b0, cur.ksum} + {33'b0, r_k};
    assign ps_add = {1'b0, cur.psum} + {1'b0, pterm};
    always_comb begin
        upd.count = (cur.count != srba_pkg::COUNT_MAX) ? (cur.count + 30'd1) : cur.count;
        upd.ksum  = ks_add[64] ? '1 : ks_add[63:0];
        upd.psum  = ps_add[64] ? '1 : ps_add[63:0];
    end

    // nonempty bins above the one being reported
    assign above  = (r_valid >> r_rob) >> 1;
    assign ro_fin = (above == '0);

    // control outputs
    always_comb begin
        o_in_ready = 1'b0;
        out_load   = 1'b0;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        mem_raddr  = r_bin;
        clr_valid  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (r_state)
            srba_pkg::ST_IDLE: o_in_ready = 1'b1;
            srba_pkg::ST_KX: begin
                mul_a = {21'b0, srba_pkg::wrap_mag(r_item.index_x, r_grid)};
                mul_b = r_kst;
            end
            srba_pkg::ST_KY: begin
                mul_a = {21'b0, srba_pkg::wrap_mag(r_item.index_y, r_grid)};
                mul_b = r_kst;
            end
            srba_pkg::ST_KZ: begin
                mul_a = {22'b0, r_item.index_z};
                mul_b = r_ksl;
            end
            srba_pkg::ST_SQX: begin mul_a = r_kx; mul_b = r_kx; end
            srba_pkg::ST_SQY: begin mul_a = r_ky; mul_b = r_ky; end
            srba_pkg::ST_SQZ: begin mul_a = r_kz; mul_b = r_kz; end
            srba_pkg::ST_BIN: begin mul_a = r_hi[31:0]; mul_b = {16'b0, r_grow}; end
            srba_pkg::ST_ABSR: begin mul_a = ar; mul_b = ar; end
            srba_pkg::ST_ABSI: begin mul_a = ai; mul_b = ai; end
            srba_pkg::ST_LMUL: begin mul_a = r_opa[r_li]; mul_b = l_b; end
            srba_pkg::ST_RD: mem_re = 1'b1;
            srba_pkg::ST_WR: mem_we = 1'b1;
            srba_pkg::ST_RO_RD: begin
                mem_raddr = r_rob;
                mem_re    = r_valid[r_rob];
                clr_valid = !r_valid[r_rob] && (r_rob == srba_pkg::BIN_W'(srba_pkg::MAX_BINS - 1));
            end
            srba_pkg::ST_PUT: begin
                out_load  = !r_ov || i_out_ready;
                clr_valid = out_load && ro_fin;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srba_pkg::ST_IDLE:
                if (in_acc) begin
                    n_state = (i_in_item.index_x == '0 || i_in_item.index_y == '0)
                            ? srba_pkg::ST_LAST : srba_pkg::ST_KX;
                end
            srba_pkg::ST_KX:  n_state = srba_pkg::ST_KY;
            srba_pkg::ST_KY:  n_state = srba_pkg::ST_KZ;
            srba_pkg::ST_KZ:  n_state = srba_pkg::ST_SQX;
            srba_pkg::ST_SQX: n_state = srba_pkg::ST_SQY;
            srba_pkg::ST_SQY: n_state = srba_pkg::ST_SQZ;
            srba_pkg::ST_SQZ:
                n_state = (r_kovf || r_sovf || ss_add[64]) ? srba_pkg::ST_BIN
                                                            : srba_pkg::ST_SQRT;
            srba_pkg::ST_SQRT: if (sq_done) n_state = srba_pkg::ST_BIN;
            srba_pkg::ST_BIN:
                if (!bin_live) begin
                    n_state = srba_pkg::ST_LAST;
                end else if (bin_hit) begin
                    n_state = srba_pkg::ST_ABSR;
                end
            srba_pkg::ST_ABSR: n_state = srba_pkg::ST_ABSI;
            srba_pkg::ST_ABSI: n_state = srba_pkg::ST_LMUL;
            srba_pkg::ST_LMUL: if (l_done && r_stage == 2'd3) n_state = srba_pkg::ST_RD;
            srba_pkg::ST_RD:   n_state = srba_pkg::ST_WR;
            srba_pkg::ST_WR:   n_state = srba_pkg::ST_LAST;
            srba_pkg::ST_LAST:
                n_state = r_item.last_coef ? srba_pkg::ST_RO_RD : srba_pkg::ST_IDLE;
            srba_pkg::ST_RO_RD:
                if (r_valid[r_rob]) begin
                    n_state = srba_pkg::ST_RO_CHK;
                end else if (clr_valid) begin
                    n_state = srba_pkg::ST_IDLE;
                end
            srba_pkg::ST_RO_CHK: n_state = srba_pkg::ST_DIVK;
            srba_pkg::ST_DIVK:  if (dv_done) n_state = srba_pkg::ST_DIVP;
            srba_pkg::ST_DIVP:  if (dv_done) n_state = srba_pkg::ST_RSQRT;
            srba_pkg::ST_RSQRT: if (sq_done) n_state = srba_pkg::ST_DIVE;
            srba_pkg::ST_DIVE:  if (dv_done) n_state = srba_pkg::ST_PUT;
            srba_pkg::ST_PUT:
                if (out_load) begin
                    n_state = ro_fin ? srba_pkg::ST_IDLE : srba_pkg::ST_RO_RD;
                end
            default: n_state = srba_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= srba_pkg::ST_IDLE;
            r_valid  <= '0;
            r_ov     <= 1'b0;
            r_grid   <= srba_pkg::RST_GRID;
            r_kst    <= srba_pkg::RST_KST;
            r_ksl    <= srba_pkg::RST_KSL;
            r_fbc    <= srba_pkg::RST_FBC;
            r_grow   <= srba_pkg::RST_GROW;
            r_klim   <= srba_pkg::RST_KLIM;
            r_pscale <= srba_pkg::RST_PSCALE;
        end else begin
            r_state <= n_state;
            if (clr_valid) begin
                r_valid <= '0;
            end else if (mem_we) begin
                r_valid[r_bin] <= 1'b1;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    srba_pkg::CFG_GRID:   r_grid   <= i_cfg_data[10:0];
                    srba_pkg::CFG_KST:    r_kst    <= i_cfg_data[31:0];
                    srba_pkg::CFG_KSL:    r_ksl    <= i_cfg_data[31:0];
                    srba_pkg::CFG_FBC:    r_fbc    <= i_cfg_data[31:0];
                    srba_pkg::CFG_GROW:   r_grow   <= i_cfg_data[15:0];
                    srba_pkg::CFG_KLIM:   r_klim   <= i_cfg_data[31:0];
                    srba_pkg::CFG_PSCALE: r_pscale <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // bin memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_bin] <= upd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            srba_pkg::ST_IDLE: if (in_acc) r_item <= i_in_item;
            srba_pkg::ST_KX: begin r_kx <= mul_p[31:0]; r_kovf <= |mul_p[63:32]; end
            srba_pkg::ST_KY: begin r_ky <= mul_p[31:0]; r_kovf <= r_kovf | (|mul_p[63:32]); end
            srba_pkg::ST_KZ: begin r_kz <= mul_p[31:0]; r_kovf <= r_kovf | (|mul_p[63:32]); end
            srba_pkg::ST_SQX: begin r_ssum <= mul_p; r_sovf <= 1'b0; end
            srba_pkg::ST_SQY: begin r_ssum <= ss_add[63:0]; r_sovf <= ss_add[64]; end
            srba_pkg::ST_SQZ: begin
                r_k      <= 32'hFFFF_FFFF;
                r_sq_v   <= ss_add[63:0];
                r_sq_res <= '0;
                r_sq_bit <= 64'h4000_0000_0000_0000;
                r_lo     <= '0;
                r_hi     <= {2'b0, r_fbc};
                r_ct     <= '0;
            end
            srba_pkg::ST_SQRT: begin
                r_sq_v   <= sq_v_n;
                r_sq_res <= sq_res_n;
                r_sq_bit <= r_sq_bit >> 2;
                if (sq_done) r_k <= sq_res_n[31:0];
            end
            srba_pkg::ST_BIN: begin
                r_bin <= r_ct[srba_pkg::BIN_W-1:0];
                r_ct  <= r_ct + 1'b1;
                r_lo  <= r_hi[31:0];
                r_hi  <= mul_p[47:14];
            end
            srba_pkg::ST_ABSR: r_m <= mul_p;
            srba_pkg::ST_ABSI: begin
                r_m      <= r_m + mul_p;
                r_opa[0] <= r_k;
                for (int q = 1; q < 5; q++) r_opa[q] <= '0;
                for (int q = 0; q < 7; q++) r_acc[q] <= '0;
                r_li     <= '0;
                r_lj     <= 1'b0;
                r_stage  <= '0;
                r_carry  <= '0;
            end
            srba_pkg::ST_LMUL: begin
                if (!l_jlast) begin
                    r_acc   <= acc_upd;
                    r_lj    <= 1'b1;
                    r_carry <= l_t[63:32];
                end else begin
                    r_lj    <= 1'b0;
                    r_carry <= '0;
                    if (!l_ilast) begin
                        r_acc <= acc_upd;
                        r_li  <= r_li + 3'd1;
                    end else if (r_stage != 2'd3) begin
                        for (int q = 0; q < 5; q++) r_opa[q] <= acc_upd[q];
                        for (int q = 0; q < 7; q++) r_acc[q] <= '0;
                        r_li    <= '0;
                        r_stage <= r_stage + 2'd1;
                    end else begin
                        r_acc <= acc_upd;
                    end
                end
            end
            srba_pkg::ST_LAST: r_rob <= srba_pkg::BIN_W'(1);
            srba_pkg::ST_RO_RD:
                if (!r_valid[r_rob] && !clr_valid) r_rob <= r_rob + 1'b1;
            srba_pkg::ST_RO_CHK: begin
                r_cnt    <= r_rdata.count;
                r_ps     <= r_rdata.psum;
                r_dv_num <= {16'b0, r_rdata.ksum};
                r_dv_div <= {2'b0, r_rdata.count};
                r_dv_rem <= '0;
                r_dv_cnt <= srba_pkg::DV_CNT_W'(srba_pkg::DV_W - 1);
            end
            srba_pkg::ST_DIVK, srba_pkg::ST_DIVP, srba_pkg::ST_DIVE: begin
                if (!dv_done) begin
                    r_dv_num <= {r_dv_num[srba_pkg::DV_W-2:0], dv_ge};
                    r_dv_rem <= dv_ge ? dv_sub[31:0] : dv_sh[31:0];
                    r_dv_cnt <= r_dv_cnt - 1'b1;
                end else begin
                    r_dv_rem <= '0;
                    r_dv_cnt <= srba_pkg::DV_CNT_W'(srba_pkg::DV_W - 1);
                    if (r_state == srba_pkg::ST_DIVK) begin
                        r_mk     <= (|r_dv_num[srba_pkg::DV_W-2:31]) ? 32'hFFFF_FFFF
                                  : {r_dv_num[30:0], dv_ge};
                        r_dv_num <= {16'b0, r_ps};
                    end else begin
                        // final quotient stays in the dividend register
                        r_dv_num <= {r_dv_num[srba_pkg::DV_W-2:0], dv_ge};
                        if (r_state == srba_pkg::ST_DIVP) begin
                            r_mp     <= {r_dv_num[62:0], dv_ge};
                            r_sq_v   <= {2'b0, r_cnt, 32'b0};
                            r_sq_res <= '0;
                            r_sq_bit <= 64'h4000_0000_0000_0000;
                        end
                    end
                end
            end
            srba_pkg::ST_RSQRT: begin
                r_sq_v   <= sq_v_n;
                r_sq_res <= sq_res_n;
                r_sq_bit <= r_sq_bit >> 2;
                if (sq_done) begin
                    r_dv_num <= {r_mp, 16'b0};
                    r_dv_div <= sq_res_n[31:0];
                end
            end
            srba_pkg::ST_PUT:
                if (out_load) begin
                    r_out.bin_number      <= r_rob;
                    r_out.mode_count      <= r_cnt;
                    r_out.mean_wavenumber <= r_mk;
                    r_out.mean_power      <= r_mp;
                    r_out.power_error     <= r_dv_num[63:0];
                    r_out.final_bin       <= ro_fin;
                    r_rob                 <= r_rob + 1'b1;
                end
            default: ;
        endcase
    end

    // a written bin reads as nonempty afterwards
    a_we_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_valid[$past(r_bin)])
        else $error("bin write did not mark entry valid");

    // only nonempty bins from 1 up are reported
    a_report_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_rob != '0) && r_valid[r_rob])
        else $error("reported bin is empty or bin zero");

    // the final result of a readout leaves all bins cleared
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && ro_fin) |=> (r_valid == '0) && (r_state == srba_pkg::ST_IDLE))
        else $error("bins not cleared after readout");

endmodule
`default_nettype wire

[tb/spectrum_radial_bin_accumulator_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_radial_bin_accumulator_unit_tb
// Streams coefficients through the radial bin accumulator in several
// register settings and compares every reported bin with a local predictor.
// ----------------------------------------------------------------------------
module spectrum_radial_bin_accumulator_unit_tb;

    localparam int NBINS = 32;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    srba_pkg::t_in_item  i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    srba_pkg::t_out_item o_out_item;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [2:0]          i_cfg_index = '0;
    logic [47:0]         i_cfg_data = '0;

    spectrum_radial_bin_accumulator_unit DUT (.*);

    always #1 i_clk = ~i_clk;

    // predictor copy of the registers and bin stores
    logic [10:0]  grid_q;
    logic [31:0]  kst_q, ksl_q, fbc_q, klim_q;
    logic [15:0]  grow_q;
    logic [47:0]  pscale_q;
    logic [29:0]  cnt_q  [NBINS];
    logic [63:0]  ksum_q [NBINS];
    logic [63:0]  psum_q [NBINS];

    srba_pkg::t_in_item  coef_queue[$];
    srba_pkg::t_out_item bin_report_queue[$];
    int        errors = 0;
    int        n_coefs = 0, n_reports = 0, n_readouts = 0;

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] res, bit_w;
        res = '0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] fold_index(logic [9:0] n);
        logic [63:0] nn, d;
        nn = 64'(n);
        d = 64'(grid_q);
        if (nn > (d >> 1)) return (nn <= d) ? d - nn : nn - d;
        return nn;
    endfunction

    function automatic logic [31:0] wavenumber(logic [63:0] kx, logic [63:0] ky,
                                               logic [63:0] kz);
        logic [128:0] s;
        logic [63:0]  r;
        if (kx[63:32] != 0 || ky[63:32] != 0 || kz[63:32] != 0) return '1;
        s = kx * kx + ky * ky + kz * kz;
        if (s[128:64] != 0) return '1;
        r = root64(s[63:0]);
        return (r[63:32] != 0) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function automatic int bin_of(logic [31:0] k);
        logic [63:0] lo, hi;
        int ct;
        lo = '0;
        hi = 64'(fbc_q);
        ct = 0;
        while (hi < 64'(klim_q) && ct < NBINS) begin
            if (64'(k) >= lo && 64'(k) < hi) return ct;
            ct++;
            lo = hi;
            hi = (hi * 64'(grow_q)) >> 14;
        end
        return -1;
    endfunction

    function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = 65'(a) + 65'(b);
        return s[64] ? '1 : s[63:0];
    endfunction

    // one coefficient: accumulate, and on last append the readout
    function automatic void predict_coef(srba_pkg::t_in_item it);
        logic [31:0]  k, ar, ai;
        logic [63:0]  m, c, mk, mp, d;
        logic [223:0] prod;
        logic [63:0]  pterm;
        int b, first;
        if (it.index_x != 0 && it.index_y != 0) begin
            k = wavenumber(fold_index(it.index_x) * 64'(kst_q),
                           fold_index(it.index_y) * 64'(kst_q),
                           64'(it.index_z) * 64'(ksl_q));
            b = bin_of(k);
            if (b >= 0) begin
                ar = it.coef_real[31] ? -it.coef_real : it.coef_real;
                ai = it.coef_imag[31] ? -it.coef_imag : it.coef_imag;
                m = 64'(ar) * 64'(ar) + 64'(ai) * 64'(ai);
                prod = 224'(k) * 224'(k) * 224'(k) * 224'(m) * 224'(pscale_q);
                pterm = (prod[223:208] != 0) ? '1 : prod[207:144];
                if (cnt_q[b] != srba_pkg::COUNT_MAX) cnt_q[b]++;
                ksum_q[b] = sadd(ksum_q[b], 64'(k));
                psum_q[b] = sadd(psum_q[b], pterm);
            end
        end
        if (it.last_coef) begin
            first = bin_report_queue.size();
            for (int i = 1; i < NBINS; i++) begin
                srba_pkg::t_out_item o;
                if (cnt_q[i] == 0) continue;
                c = 64'(cnt_q[i]);
                mk = ksum_q[i] / c;
                mp = psum_q[i] / c;
                d = root64(c << 32);
                o.bin_number = i[4:0];
                o.mode_count = c[29:0];
                o.mean_wavenumber = (mk[63:32] != 0) ? 32'hFFFF_FFFF : mk[31:0];
                o.mean_power = mp;
                o.power_error = ((mp / d) << 16) + (((mp % d) << 16) / d);
                o.final_bin = 1'b0;
                bin_report_queue.push_back(o);
            end
            if (bin_report_queue.size() > first)
                bin_report_queue[bin_report_queue.size() - 1].final_bin = 1'b1;
            n_readouts++;
            for (int i = 0; i < NBINS; i++) begin
                cnt_q[i] = '0; ksum_q[i] = '0; psum_q[i] = '0;
            end
        end
    endfunction

    // driver: pops pending coefficients, random gap before each
    int drive_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_coef(i_in_item);
                n_coefs++;
                void'(coef_queue.pop_front());
                i_in_valid <= 1'b0;
                drive_gap = $urandom_range(0, 4);
            end else if (!i_in_valid) begin
                if (drive_gap > 0) begin
                    drive_gap--;
                end else if (coef_queue.size() > 0) begin
                    i_in_item  <= coef_queue[0];
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // monitor: random stalls on ready, compares each report with the oldest one expected
    int stall = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (bin_report_queue.size() == 0) begin
                    $display("%0t: unexpected bin report %p", $time, o_out_item);
                    errors++;
                end else begin
                    srba_pkg::t_out_item e;
                    e = bin_report_queue.pop_front();
                    if (e !== o_out_item) begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, o_out_item);
                        errors++;
                    end
                end
                n_reports++;
                stall = $urandom_range(0, 4);
                i_out_ready <= (stall == 0);
            end else if (stall > 0) begin
                stall--;
                i_out_ready <= (stall == 0);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(srba_pkg::t_cfg_idx idx, logic [47:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            srba_pkg::CFG_GRID:   grid_q   = v[10:0];
            srba_pkg::CFG_KST:    kst_q    = v[31:0];
            srba_pkg::CFG_KSL:    ksl_q    = v[31:0];
            srba_pkg::CFG_FBC:    fbc_q    = v[31:0];
            srba_pkg::CFG_GROW:   grow_q   = v[15:0];
            srba_pkg::CFG_KLIM:   klim_q   = v[31:0];
            srba_pkg::CFG_PSCALE: pscale_q = v;
            default: ;
        endcase
    endtask

    // wait until every coefficient is taken and every report seen, then settle
    task automatic drain();
        int guard;
        guard = 0;
        while ((coef_queue.size() != 0 || i_in_valid || bin_report_queue.size() != 0)
               && guard < 2000000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (200) @(posedge i_clk);
    endtask

    function automatic srba_pkg::t_in_item coef(int x, int y, int z, logic [31:0] re,
                                                logic [31:0] im, bit last);
        srba_pkg::t_in_item it;
        it.index_x = x[9:0]; it.index_y = y[9:0]; it.index_z = z[9:0];
        it.coef_real = re; it.coef_imag = im; it.last_coef = last;
        return it;
    endfunction

    function automatic srba_pkg::t_in_item rand_coef(int g, bit last);
        srba_pkg::t_in_item it;
        // mostly in-grid indices, some raw full-range noise
        if ($urandom_range(0, 5) == 0) begin
            it.index_x = 10'($urandom);
            it.index_y = 10'($urandom);
            it.index_z = 10'($urandom);
        end else begin
            it.index_x = 10'($urandom_range(0, g - 1));
            it.index_y = 10'($urandom_range(0, g - 1));
            it.index_z = 10'($urandom_range(0, g / 2));
        end
        it.coef_real = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 20)
                       - (1 << 19);
        it.coef_imag = $urandom;
        it.last_coef = last;
        return it;
    endfunction

    // random phase: small batches each closed by a last coefficient
    task automatic random_batch(int n, int g);
        for (int i = 0; i < n; i++)
            coef_queue.push_back(rand_coef(g, (i % 12 == 11) || (i == n - 1)));
        drain();
    endtask

    initial begin
        grid_q = srba_pkg::RST_GRID; kst_q = srba_pkg::RST_KST;
        ksl_q = srba_pkg::RST_KSL; fbc_q = srba_pkg::RST_FBC;
        grow_q = srba_pkg::RST_GROW; klim_q = srba_pkg::RST_KLIM;
        pscale_q = srba_pkg::RST_PSCALE;
        for (int i = 0; i < NBINS; i++) begin
            cnt_q[i] = '0; ksum_q[i] = '0; psum_q[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, extremes, skipped indices, wrap, empty readout
        coef_queue.push_back(coef(0, 0, 0, 0, 0, 1));           // empty readout
        coef_queue.push_back(coef(0, 5, 3, 32'h7FFF_FFFF, 0, 0)); // zero x skipped
        coef_queue.push_back(coef(5, 0, 3, 0, 32'h8000_0000, 0)); // zero y skipped
        coef_queue.push_back(coef(1, 1, 0, 32'h0001_0000, 32'hFFFF_0000, 0));
        coef_queue.push_back(coef(127, 127, 1, 32'h8000_0000, 32'h8000_0000, 0));
        coef_queue.push_back(coef(64, 65, 64, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        coef_queue.push_back(coef(1023, 1023, 1023, 32'hFFFF_FFFF, 1, 0));
        coef_queue.push_back(coef(10, 20, 30, 32'h1234_5678, 32'h8765_4321, 0));
        coef_queue.push_back(coef(3, 125, 5, 32'h0, 32'h0, 0));
        coef_queue.push_back(coef(40, 90, 512, 32'h5555_5555, 32'hAAAA_AAAA, 1));
        coef_queue.push_back(coef(2, 2, 2, 32'h0100_0000, 0, 1));
        drain();

        // extremes: smallest grid, widest steps, tiny growth, full scale
        write_reg(srba_pkg::CFG_GRID, 48'd2);
        write_reg(srba_pkg::CFG_KST, 48'hFFFF_FFFF);
        write_reg(srba_pkg::CFG_KSL, 48'd1);
        write_reg(srba_pkg::CFG_FBC, 48'd1);
        write_reg(srba_pkg::CFG_GROW, 48'd16385);
        write_reg(srba_pkg::CFG_KLIM, 48'hFFFF_FFFF);
        write_reg(srba_pkg::CFG_PSCALE, 48'hFFFF_FFFF_FFFF);
        coef_queue.push_back(coef(1, 1, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0));
        coef_queue.push_back(coef(1, 3, 512, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
        drain();
        random_batch(20, 2);

        // largest grid, fast growth, saturating power
        write_reg(srba_pkg::CFG_GRID, 48'd1024);
        write_reg(srba_pkg::CFG_KST, 48'd40000);
        write_reg(srba_pkg::CFG_KSL, 48'd70000);
        write_reg(srba_pkg::CFG_FBC, 48'd100000);
        write_reg(srba_pkg::CFG_GROW, 48'd65535);
        write_reg(srba_pkg::CFG_KLIM, 48'hFFFF_FFFF);
        random_batch(60, 1024);

        // moderate growth spreading over many bins, minimal limits
        write_reg(srba_pkg::CFG_GRID, 48'd200);
        write_reg(srba_pkg::CFG_KST, 48'd300000);
        write_reg(srba_pkg::CFG_KSL, 48'd1);
        write_reg(srba_pkg::CFG_FBC, 48'd200000);
        write_reg(srba_pkg::CFG_GROW, 48'd18000);
        write_reg(srba_pkg::CFG_KLIM, 48'd1);
        write_reg(srba_pkg::CFG_PSCALE, 48'd1);
        random_batch(12, 200);
        write_reg(srba_pkg::CFG_KLIM, 48'd900000000);
        write_reg(srba_pkg::CFG_PSCALE, 48'd34610000000);
        random_batch(60, 200);

        // back to reset settings, odd grid
        write_reg(srba_pkg::CFG_GRID, 48'd127);
        write_reg(srba_pkg::CFG_KST, 48'd351382);
        write_reg(srba_pkg::CFG_KSL, 48'd351382);
        write_reg(srba_pkg::CFG_FBC, 48'd351382);
        write_reg(srba_pkg::CFG_GROW, 48'd22118);
        write_reg(srba_pkg::CFG_KLIM, 48'd44976896);
        random_batch(60, 127);

        $display("Ran %0d coefficients through %0d readouts, %0d bin reports checked.",
                 n_coefs, n_readouts, n_reports);
        $display("Register settings covered grid 2..1024, growth 16385..65535.");
        if (errors == 0 && bin_report_queue.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
sv/srba_pkg.sv
sv/spectrum_radial_bin_accumulator_unit.sv
tb/spectrum_radial_bin_accumulator_unit_tb.sv
